@@ design/fdtdte_pkg.sv @@
// shared types, constants and codes of the 2d te curl update block
`timescale 1ns / 1ps

package fdtdte_pkg;

    localparam int FIELD_BITS      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int COORD_BITS      = 7;
    localparam int CNT_BITS        = 7;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;
    localparam int DEF_GRID_SIDE   = 128;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [CNT_BITS-1:0] CELLS_RESET = CNT_BITS'(126);

    typedef logic signed [FIELD_BITS-1:0] field_t;
    typedef logic [COORD_BITS-1:0]        coord_t;
    // shifted coordinate, holds 0..128, or 255 where it wrapped below zero
    typedef logic [COORD_BITS:0]          pos_t;

    typedef enum logic
    {
        KIND_BASE_WRITE = 1'b0,
        KIND_UPDATE     = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_CELLS_X        = 3'd0,
        REG_CELLS_Y        = 3'd1,
        REG_OUTER_MODE     = 3'd2,
        REG_H_FACED        = 3'd3,
        REG_PER_CELL_COEF  = 3'd4,
        REG_UNIFORM_COEF_X = 3'd5,
        REG_UNIFORM_COEF_Y = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_WRITE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_DIFF,
        ST_MUL,
        ST_SCALE,
        ST_ADD
    } back_state_t;

    // classified work item handed from front to back
    typedef struct packed
    {
        kind_t  kind;
        logic   wr_ok;
        logic   ok_a;
        logic   ok_b;
        logic   ok_c;
        logic   ux;
        logic   uy;
        logic   neg_x;
        logic   neg_y;
        pos_t   row;
        pos_t   col;
        pos_t   row_s;
        pos_t   col_s;
        field_t value_x;
        field_t value_y;
        field_t coef_x;
        field_t coef_y;
    } work_t;

endpackage

@@ design/fdtdte_if.sv @@
// channel interfaces: items in, results out, configuration writes
`timescale 1ns / 1ps

interface fdtdte_in_if import fdtdte_pkg::*; ();
    logic   valid;
    logic   ready;
    kind_t  kind;
    coord_t row;
    coord_t col;
    field_t value_x;
    field_t value_y;
    field_t coef_x;
    field_t coef_y;

    modport source (output valid, output kind, output row, output col, output value_x,
                    output value_y, output coef_x, output coef_y, input ready);
    modport sink   (input valid, input kind, input row, input col, input value_x,
                    input value_y, input coef_x, input coef_y, output ready);
endinterface

interface fdtdte_out_if import fdtdte_pkg::*; ();
    logic   valid;
    logic   ready;
    field_t new_x;
    field_t new_y;
    logic   x_updated;
    logic   y_updated;
    logic   saturated;

    modport source (output valid, output new_x, output new_y, output x_updated,
                    output y_updated, output saturated, input ready);
    modport sink   (input valid, input new_x, input new_y, input x_updated,
                    input y_updated, input saturated, output ready);
endinterface

interface fdtdte_cfg_if import fdtdte_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/fdtdte_front.sv @@
// front: configuration registers, item intake and cell classification
`timescale 1ns / 1ps

module fdtdte_front import fdtdte_pkg::*;
#(
    parameter int GRID_SIDE = DEF_GRID_SIDE
)
(
    input  logic        clk,
    input  logic        rst_n,
    fdtdte_cfg_if.sink  cfg,
    fdtdte_in_if.sink   items,
    output logic        push,
    output work_t       push_item,
    input  logic        full
);

    localparam int SW = COORD_BITS + 2;

    logic [CNT_BITS-1:0] cells_x_reg;
    logic [CNT_BITS-1:0] cells_y_reg;
    logic                outer_mode_reg;
    logic                h_faced_reg;
    logic                per_cell_coef_reg;
    field_t              uniform_coef_x_reg;
    field_t              uniform_coef_y_reg;

    logic [SW-1:0] row_s;
    logic [SW-1:0] col_s;
    logic          row_s_ok;
    logic          col_s_ok;
    logic          row_ok;
    logic          col_ok;
    logic [CNT_BITS:0] row_e;
    logic [CNT_BITS:0] col_e;
    logic [CNT_BITS:0] nx_e;
    logic [CNT_BITS:0] ny_e;
    logic          row_in;
    logic          col_in;

    // negative shows up as the top bit after the wrap below zero
    function automatic logic coord_ok(input logic [SW-1:0] v);
        return !v[SW-1] && (32'(v[SW-2:0]) < 32'(GRID_SIDE));
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg        <= CELLS_RESET;
            cells_y_reg        <= CELLS_RESET;
            outer_mode_reg     <= 1'b0;
            h_faced_reg        <= 1'b0;
            per_cell_coef_reg  <= 1'b0;
            uniform_coef_x_reg <= '0;
            uniform_coef_y_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_CELLS_X:        cells_x_reg        <= cfg.data[CNT_BITS-1:0];
                REG_CELLS_Y:        cells_y_reg        <= cfg.data[CNT_BITS-1:0];
                REG_OUTER_MODE:     outer_mode_reg     <= cfg.data[0];
                REG_H_FACED:        h_faced_reg        <= cfg.data[0];
                REG_PER_CELL_COEF:  per_cell_coef_reg  <= cfg.data[0];
                REG_UNIFORM_COEF_X: uniform_coef_x_reg <= field_t'(cfg.data[FIELD_BITS-1:0]);
                REG_UNIFORM_COEF_Y: uniform_coef_y_reg <= field_t'(cfg.data[FIELD_BITS-1:0]);
                default:            ;
            endcase
        end
    end

    assign items.ready = !full;
    assign push        = items.valid && !full;

    always_comb
    begin
        if (outer_mode_reg)
        begin
            row_s = SW'(items.row) - SW'(1);
            col_s = SW'(items.col) - SW'(1);
        end
        else
        begin
            row_s = SW'(items.row) + SW'(1);
            col_s = SW'(items.col) + SW'(1);
        end
        row_s_ok = coord_ok(row_s);
        col_s_ok = coord_ok(col_s);
        row_ok   = coord_ok(SW'(items.row));
        col_ok   = coord_ok(SW'(items.col));

        row_e = (CNT_BITS+1)'(items.row);
        col_e = (CNT_BITS+1)'(items.col);
        nx_e  = (CNT_BITS+1)'(cells_x_reg);
        ny_e  = (CNT_BITS+1)'(cells_y_reg);
        // strict interior rows and columns of the outer region
        row_in = (items.row != '0) && (row_e <= nx_e);
        col_in = (items.col != '0) && (col_e <= ny_e);

        push_item         = '0;
        push_item.kind    = items.kind;
        push_item.wr_ok   = row_ok && col_ok;
        push_item.ok_a    = row_s_ok && col_s_ok;
        push_item.ok_b    = row_s_ok && col_ok;
        push_item.ok_c    = row_ok && col_s_ok;
        push_item.neg_x   = !h_faced_reg;
        push_item.neg_y   = h_faced_reg;
        push_item.row     = pos_t'(items.row);
        push_item.col     = pos_t'(items.col);
        push_item.row_s   = row_s[SW-2:0];
        push_item.col_s   = col_s[SW-2:0];
        push_item.value_x = items.value_x;
        push_item.value_y = items.value_y;
        push_item.coef_x  = per_cell_coef_reg ? items.coef_x : uniform_coef_x_reg;
        push_item.coef_y  = per_cell_coef_reg ? items.coef_y : uniform_coef_y_reg;

        if (!outer_mode_reg)
        begin
            push_item.ux = (row_e <= nx_e) && (col_e <= ny_e);
            push_item.uy = (row_e <= nx_e) && (col_e <= ny_e);
        end
        else
        begin
            // edge strips update one component, the corner none
            push_item.ux = col_in && (row_in || (row_e == nx_e + 1'b1));
            push_item.uy = row_in && (col_in || (col_e == ny_e + 1'b1));
        end
    end

endmodule

@@ design/fdtdte_queue.sv @@
// short fifo of classified work items between front and back
`timescale 1ns / 1ps

module fdtdte_queue import fdtdte_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_item,
    output logic  full,
    input  logic  pop,
    output work_t pop_item,
    output logic  empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    work_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/fdtdte_back.sv @@
// back: base grid memory, three-read sequencer, curl arithmetic, result register
`timescale 1ns / 1ps

module fdtdte_back import fdtdte_pkg::*;
#(
    parameter int GRID_SIDE = DEF_GRID_SIDE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  work_t         pop_item,
    input  logic          empty,
    output logic          pop,
    fdtdte_out_if.source  results
);

    localparam int MEM_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DIFF_W    = FIELD_BITS + 1;
    localparam int MUL_W     = FIELD_BITS + DIFF_W;
    localparam int PROD_W    = MUL_W + 1;
    localparam int SCALED_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SCALED_W + 1;
    localparam int TOP_W     = SUM_W - FIELD_BITS + 1;

    localparam field_t FIELD_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam field_t FIELD_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};

    field_t grid_mem [MEM_DEPTH];

    back_state_t state_reg;
    back_state_t state_next;
    work_t       item_reg;

    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    field_t            rdata_reg;
    field_t            rdata_masked;
    field_t            a_reg;
    field_t            b_reg;

    logic signed [DIFF_W-1:0]   dy_reg;
    logic signed [DIFF_W-1:0]   dx_reg;
    logic signed [MUL_W-1:0]    px_reg;
    logic signed [MUL_W-1:0]    py_reg;
    logic signed [PROD_W-1:0]   prod_x;
    logic signed [PROD_W-1:0]   prod_y;
    logic signed [SCALED_W-1:0] qx_reg;
    logic signed [SCALED_W-1:0] qy_reg;
    logic signed [SUM_W-1:0]    sum_x;
    logic signed [SUM_W-1:0]    sum_y;
    logic [TOP_W-1:0]           top_x;
    logic [TOP_W-1:0]           top_y;
    logic                       ovf_x;
    logic                       ovf_y;
    field_t                     res_x;
    field_t                     res_y;

    logic   out_valid_reg;
    field_t out_x_reg;
    field_t out_y_reg;
    logic   out_ux_reg;
    logic   out_uy_reg;
    logic   out_sat_reg;
    logic   load_out;

    function automatic logic [ADDR_W-1:0] cell_addr(input pos_t r, input pos_t c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIDE) + ADDR_W'(c));
    endfunction

    // single port, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= item_reg.value_x;
        end
        rdata_reg <= grid_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = cell_addr(item_reg.row_s, item_reg.col_s);
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = !empty;
                if (!empty)
                begin
                    state_next = (pop_item.kind == KIND_UPDATE) ? ST_RD_A : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_addr   = cell_addr(item_reg.row, item_reg.col);
                mem_we     = item_reg.wr_ok;
                state_next = ST_IDLE;
            end
            ST_RD_A:
            begin
                mem_addr   = cell_addr(item_reg.row_s, item_reg.col_s);
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                mem_addr   = cell_addr(item_reg.row_s, item_reg.col);
                state_next = ST_RD_C;
            end
            ST_RD_C:
            begin
                mem_addr   = cell_addr(item_reg.row, item_reg.col_s);
                state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ADD;
            ST_ADD:
            begin
                // hold here while the previous result is still unclaimed
                if (!out_valid_reg || results.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // reads beyond the grid give zero
    always_comb
    begin
        case (state_reg)
            ST_RD_B: rdata_masked = item_reg.ok_a ? rdata_reg : '0;
            ST_RD_C: rdata_masked = item_reg.ok_b ? rdata_reg : '0;
            ST_DIFF: rdata_masked = item_reg.ok_c ? rdata_reg : '0;
            default: rdata_masked = '0;
        endcase
    end

    always_comb
    begin
        prod_x = PROD_W'(px_reg);
        prod_y = PROD_W'(py_reg);
        if (item_reg.neg_x)
        begin
            prod_x = -prod_x;
        end
        if (item_reg.neg_y)
        begin
            prod_y = -prod_y;
        end

        sum_x = SUM_W'(item_reg.value_x) + SUM_W'(qx_reg);
        sum_y = SUM_W'(item_reg.value_y) + SUM_W'(qy_reg);
        top_x = sum_x[SUM_W-1:FIELD_BITS-1];
        top_y = sum_y[SUM_W-1:FIELD_BITS-1];
        ovf_x = !((&top_x) || !(|top_x));
        ovf_y = !((&top_y) || !(|top_y));

        if (!item_reg.ux)
        begin
            res_x = item_reg.value_x;
        end
        else if (ovf_x)
        begin
            res_x = sum_x[SUM_W-1] ? FIELD_MIN : FIELD_MAX;
        end
        else
        begin
            res_x = sum_x[FIELD_BITS-1:0];
        end

        if (!item_reg.uy)
        begin
            res_y = item_reg.value_y;
        end
        else if (ovf_y)
        begin
            res_y = sum_y[SUM_W-1] ? FIELD_MIN : FIELD_MAX;
        end
        else
        begin
            res_y = sum_y[FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
        end
        if (state_reg == ST_RD_B)
        begin
            a_reg <= rdata_masked;
        end
        if (state_reg == ST_RD_C)
        begin
            b_reg <= rdata_masked;
        end
        if (state_reg == ST_DIFF)
        begin
            dy_reg <= DIFF_W'(a_reg) - DIFF_W'(b_reg);
            dx_reg <= DIFF_W'(a_reg) - DIFF_W'(rdata_masked);
        end
        if (state_reg == ST_MUL)
        begin
            px_reg <= MUL_W'(item_reg.coef_x) * MUL_W'(dy_reg);
            py_reg <= MUL_W'(item_reg.coef_y) * MUL_W'(dx_reg);
        end
        // floor division by the fraction scale
        if (state_reg == ST_SCALE)
        begin
            qx_reg <= prod_x[PROD_W-1:FRAC_BITS];
            qy_reg <= prod_y[PROD_W-1:FRAC_BITS];
        end
        if (load_out)
        begin
            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
            out_ux_reg  <= item_reg.ux;
            out_uy_reg  <= item_reg.uy;
            out_sat_reg <= (item_reg.ux && ovf_x) || (item_reg.uy && ovf_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.new_x     = out_x_reg;
    assign results.new_y     = out_y_reg;
    assign results.x_updated = out_ux_reg;
    assign results.y_updated = out_uy_reg;
    assign results.saturated = out_sat_reg;

    a_pop_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_WRITE || state_reg == ST_RD_A))
        else $error("popped item did not start a write or a read sequence");

    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_C |-> $past(state_reg) == ST_RD_B)
        else $error("third base read not preceded by the second");

    a_result_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && out_valid_reg && !results.ready) |=>
        (state_reg == ST_ADD && out_valid_reg))
        else $error("pending result overrun by the next update");

    a_sat_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> (out_ux_reg || out_uy_reg))
        else $error("saturation flagged with no component updated");

endmodule

@@ design/fdtd_te_curl_update_2d_top.sv @@
// top level of the 2d te curl update block
//
// channel  dir  beat contents
// cfg      in   index, data (register write)
// items    in   kind, row, col, value_x, value_y, coef_x, coef_y
// results  out  new_x, new_y, x_updated, y_updated, saturated
//
// a base write passes through the back end's write state, a cell update through
// three reads of the single-port grid memory, then diff, multiply, scale, add
// items are taken into a 2-deep queue while the back end works, so input
// stalls only when the queue is full; a waiting result stalls the back end
// only at its final add step. cfg is always ready and takes one write a cycle
// reset clears control state and loads register defaults; grid memory is not cleared
`timescale 1ns / 1ps

module fdtd_te_curl_update_2d_top import fdtdte_pkg::*;
#(
    parameter int GRID_SIDE   = DEF_GRID_SIDE,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    fdtdte_cfg_if.sink    cfg,
    fdtdte_in_if.sink     items,
    fdtdte_out_if.source  results
);

    logic  push;
    work_t push_item;
    logic  full;
    logic  pop;
    work_t pop_item;
    logic  empty;

    fdtdte_front #(.GRID_SIDE(GRID_SIDE)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .items     (items),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    fdtdte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    fdtdte_back #(.GRID_SIDE(GRID_SIDE)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_item (pop_item),
        .empty    (empty),
        .pop      (pop),
        .results  (results)
    );

endmodule
